### hw/rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, constants and calendar helpers for the daylight rule selector.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int YEAR_W  = 14;
  localparam int TIME_W  = 64;
  localparam int OFF_W   = 18;
  localparam int DATE_W  = 16;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int YDAYS_W = 23;
  localparam int DAYS_W  = 25;
  localparam int DOFF_W  = 11;
  localparam int CHG_W   = 42;
  localparam int ZSUM_W  = 11;

  localparam logic [KIND_W-1:0] KIND_ZERO_DAY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_JULIAN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MWD      = 2'd2;

  localparam logic [2:0] REG_STD_KIND = 3'd0;
  localparam logic [2:0] REG_STD_DATE = 3'd1;
  localparam logic [2:0] REG_STD_TIME = 3'd2;
  localparam logic [2:0] REG_STD_OFF  = 3'd3;
  localparam logic [2:0] REG_DST_KIND = 3'd4;
  localparam logic [2:0] REG_DST_DATE = 3'd5;
  localparam logic [2:0] REG_DST_TIME = 3'd6;
  localparam logic [2:0] REG_DST_OFF  = 3'd7;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
  localparam logic [YDAYS_W-1:0] LEAP_BIAS = 23'd477;
  localparam logic signed [CHG_W-1:0] SECS_PER_DAY = 42'sd86400;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [DATE_W-1:0]       date;
    logic signed [OFF_W-1:0] rtime;
    logic signed [OFF_W-1:0] offset;
  } rule_cfg_t;

  localparam rule_cfg_t STD_CFG_RESET = '{kind: 2'd2, date: 16'd12314,
                                          rtime: 18'sd7200, offset: 18'sd0};
  localparam rule_cfg_t DST_CFG_RESET = '{kind: 2'd2, date: 16'd13312,
                                          rtime: 18'sd7200, offset: 18'sd3600};

  // Quotient by 100 through a reciprocal; exact for all values below 25600.
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [26:0] prod;
    prod = 27'(x[14:2]) * 27'd5243;
    return prod[24:17];
  endfunction

  function automatic logic [14:0] mul100(input logic [7:0] q);
    return 15'({q, 6'd0}) + 15'({q, 5'd0}) + 15'({q, 2'd0});
  endfunction

  // Remainder by 7 through a reciprocal; exact for all values below 1792.
  function automatic logic [2:0] mod7(input logic [ZSUM_W-1:0] s);
    logic [23:0]         prod;
    logic [ZSUM_W-1:0]   q7;
    prod = 24'(s) * 24'd4682;
    q7   = 11'({prod[22:15], 3'd0}) - 11'(prod[22:15]);
    return 3'(s - q7);
  endfunction

  // Month term of the weekday congruence, months 1 to 12.
  function automatic logic [5:0] zel_month(input logic [3:0] mon);
    logic [5:0] r;
    case (mon)
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      default: r = 6'd33;
    endcase
    return r;
  endfunction

  // Days before the first of the month in a leap year.
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd60;
      4'd4:    r = 9'd91;
      4'd5:    r = 9'd121;
      4'd6:    r = 9'd152;
      4'd7:    r = 9'd182;
      4'd8:    r = 9'd213;
      4'd9:    r = 9'd244;
      4'd10:   r = 9'd274;
      4'd11:   r = 9'd305;
      default: r = 9'd335;
    endcase
    return r;
  endfunction

  // Month length in a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] r;
    case (mon)
      4'd2:                       r = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/drs_regs.sv
// ----------------------------------------------------------------------------
// drs_regs
// Configuration register file for the standard and daylight rules.
// ----------------------------------------------------------------------------
module drs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drs_pkg::ADDR_W-1:0]  paddr,
  input  logic [drs_pkg::DATA_W-1:0]  pwdata,
  output logic [drs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output drs_pkg::rule_cfg_t          std_cfg,
  output drs_pkg::rule_cfg_t          dst_cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      std_cfg <= drs_pkg::STD_CFG_RESET;
      dst_cfg <= drs_pkg::DST_CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        drs_pkg::REG_STD_KIND: std_cfg.kind   <= pwdata[1:0];
        drs_pkg::REG_STD_DATE: std_cfg.date   <= pwdata[15:0];
        drs_pkg::REG_STD_TIME: std_cfg.rtime  <= pwdata[17:0];
        drs_pkg::REG_STD_OFF:  std_cfg.offset <= pwdata[17:0];
        drs_pkg::REG_DST_KIND: dst_cfg.kind   <= pwdata[1:0];
        drs_pkg::REG_DST_DATE: dst_cfg.date   <= pwdata[15:0];
        drs_pkg::REG_DST_TIME: dst_cfg.rtime  <= pwdata[17:0];
        drs_pkg::REG_DST_OFF:  dst_cfg.offset <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      drs_pkg::REG_STD_KIND: prdata = 32'(std_cfg.kind);
      drs_pkg::REG_STD_DATE: prdata = 32'(std_cfg.date);
      drs_pkg::REG_STD_TIME: prdata = 32'(unsigned'(std_cfg.rtime));
      drs_pkg::REG_STD_OFF:  prdata = 32'(unsigned'(std_cfg.offset));
      drs_pkg::REG_DST_KIND: prdata = 32'(dst_cfg.kind);
      drs_pkg::REG_DST_DATE: prdata = 32'(dst_cfg.date);
      drs_pkg::REG_DST_TIME: prdata = 32'(unsigned'(dst_cfg.rtime));
      drs_pkg::REG_DST_OFF:  prdata = 32'(unsigned'(dst_cfg.offset));
      default:               prdata = '0;
    endcase
  end

endmodule

### hw/rtl/drs_year.sv
// ----------------------------------------------------------------------------
// drs_year
// Two-stage pipeline giving the leap flag and the day count from 1970 to the
// first of January of the year.
// ----------------------------------------------------------------------------
module drs_year (
  input  logic                         clk,
  input  logic [drs_pkg::YEAR_W-1:0]   year,
  output logic                         leap,
  output logic [drs_pkg::YDAYS_W-1:0]  ydays
);

  logic [drs_pkg::YEAR_W-1:0]  yr1;
  logic [7:0]                  yc1;
  logic [7:0]                  pc1;
  logic [drs_pkg::YEAR_W-1:0]  pm1;
  logic [drs_pkg::YEAR_W-1:0]  span;
  logic [6:0]                  rem100;
  logic                        leap_next;
  logic [drs_pkg::YDAYS_W-1:0] ydays_next;

  always_ff @(posedge clk) begin
    yr1 <= year;
    yc1 <= drs_pkg::div100(15'(year));
    pc1 <= drs_pkg::div100(15'(year - 14'd1));
  end

  always_comb begin
    pm1       = yr1 - 14'd1;
    span      = yr1 - drs_pkg::EPOCH_YEAR;
    rem100    = 7'(15'(yr1) - drs_pkg::mul100(yc1));
    leap_next = (yr1[1:0] == 2'd0) && ((rem100 != 7'd0) || (yc1[1:0] == 2'd0));
    if (yr1 > drs_pkg::EPOCH_YEAR) begin
      ydays_next = 23'(span) * 23'd365 + 23'(pm1[13:2]) + 23'(pc1[7:2])
                   - 23'(pc1) - drs_pkg::LEAP_BIAS;
    end else begin
      ydays_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    leap  <= leap_next;
    ydays <= ydays_next;
  end

endmodule

### hw/rtl/drs_rule.sv
// ----------------------------------------------------------------------------
// drs_rule
// Five-stage pipeline giving the UTC second at which one rule takes effect in
// the year presented at its input.
// ----------------------------------------------------------------------------
module drs_rule (
  input  logic                              clk,
  input  drs_pkg::rule_cfg_t                cfg,
  input  logic [drs_pkg::YEAR_W-1:0]        year,
  input  logic                              leap,
  input  logic [drs_pkg::YDAYS_W-1:0]       ydays,
  output logic signed [drs_pkg::CHG_W-1:0]  chg
);

  logic [8:0]  dayv;
  logic [2:0]  week;
  logic [3:0]  mon_raw;
  logic [3:0]  mon;
  logic [2:0]  wd;
  logic [14:0] zy_next;

  logic [14:0] zy1;
  logic [7:0]  zc1;
  logic [6:0]  cy;
  logic [drs_pkg::ZSUM_W-1:0] zsum_next;
  logic [drs_pkg::ZSUM_W-1:0] zsum2;

  logic [2:0]  dow3;
  logic [8:0]  cum3;
  logic [4:0]  mlen3;
  logic        leap3;
  logic [drs_pkg::YDAYS_W-1:0] ydays3;

  logic [3:0]  d0;
  logic [2:0]  kmax;
  logic [2:0]  kweek;
  logic [2:0]  k;
  logic [8:0]  mwd_day;
  logic signed [drs_pkg::DOFF_W-1:0] dayoff;
  logic signed [drs_pkg::DAYS_W-1:0] days4;
  logic signed [drs_pkg::CHG_W-1:0]  chg_next;

  always_comb begin
    dayv    = cfg.date[8:0];
    week    = cfg.date[11:9];
    mon_raw = cfg.date[15:12];
    if (mon_raw == 4'd0) begin
      mon = 4'd1;
    end else if (mon_raw > 4'd12) begin
      mon = 4'd12;
    end else begin
      mon = mon_raw;
    end
    wd      = (dayv > 9'd6) ? 3'd6 : dayv[2:0];
    zy_next = 15'(year) + ((mon < 4'd3) ? 15'd399 : 15'd400);
  end

  always_ff @(posedge clk) begin
    zy1 <= zy_next;
    zc1 <= drs_pkg::div100(zy_next);
  end

  always_comb begin
    cy        = 7'(zy1 - drs_pkg::mul100(zc1));
    zsum_next = 11'(drs_pkg::zel_month(mon)) + 11'(cy) + 11'(cy[6:2]) + 11'(zc1[7:2])
                + 11'({zc1, 2'd0}) + 11'(zc1);
  end

  always_ff @(posedge clk) begin
    zsum2 <= zsum_next;
  end

  always_ff @(posedge clk) begin
    dow3   <= drs_pkg::mod7(zsum2);
    cum3   <= drs_pkg::cum_days(mon) - 9'((mon > 4'd2) && !leap);
    mlen3  <= drs_pkg::month_len(mon) - 5'((mon == 4'd2) && !leap);
    leap3  <= leap;
    ydays3 <= ydays;
  end

  always_comb begin
    if (wd < dow3) begin
      d0 = 4'(wd) + 4'd7 - 4'(dow3);
    end else begin
      d0 = 4'(wd) - 4'(dow3);
    end
    kmax    = (6'(d0) + 6'd28 < 6'(mlen3)) ? 3'd4 : 3'd3;
    kweek   = (week == 3'd0) ? 3'd0 : week - 3'd1;
    k       = (kweek < kmax) ? kweek : kmax;
    mwd_day = cum3 + 9'(d0) + 9'({k, 3'd0}) - 9'(k);
    case (cfg.kind)
      drs_pkg::KIND_ZERO_DAY: dayoff = signed'(11'(dayv));
      drs_pkg::KIND_JULIAN:   dayoff = signed'(11'(dayv)) - 11'sd1
                                       + signed'(11'((dayv >= 9'd60) && leap3));
      default:                dayoff = signed'(11'(mwd_day));
    endcase
  end

  always_ff @(posedge clk) begin
    days4 <= signed'(25'(ydays3)) + 25'(dayoff);
  end

  assign chg_next = 42'(days4) * drs_pkg::SECS_PER_DAY + 42'(cfg.rtime) - 42'(cfg.offset);

  always_ff @(posedge clk) begin
    chg <= chg_next;
  end

endmodule

### hw/rtl/dst_rule_offset_select.sv
// ----------------------------------------------------------------------------
// dst_rule_offset_select
// Decides whether daylight time is in force at a UTC second and gives the
// matching offset, from two POSIX TZ style rules.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high and busy is low;
// busy is high while reset is applied and in the first cycle after it. The
// result appears with done high for one cycle, and a new word may be started
// every cycle while busy is low. The result passes through six register
// stages: the five of the rule pipeline (division of the year by 100, the
// weekday sum, the weekday remainder, the day count, the scaling to
// seconds) and the final comparison. The result cannot be held off, so it
// must be captured in the cycle in which done is high.
module dst_rule_offset_select (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [drs_pkg::TIME_W-1:0]  utc_seconds,
  input  logic [drs_pkg::YEAR_W-1:0]         calendar_year,
  output logic                               done,
  output logic                               is_daylight,
  output logic signed [drs_pkg::OFF_W-1:0]   utc_offset,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [drs_pkg::ADDR_W-1:0]         paddr,
  input  logic [drs_pkg::DATA_W-1:0]         pwdata,
  output logic [drs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int LAT = 5;

  drs_pkg::rule_cfg_t std_cfg;
  drs_pkg::rule_cfg_t dst_cfg;

  logic                              leap;
  logic [drs_pkg::YDAYS_W-1:0]       ydays;
  logic signed [drs_pkg::CHG_W-1:0]  chg_std;
  logic signed [drs_pkg::CHG_W-1:0]  chg_dst;

  logic [LAT-1:0]                    vld;
  logic signed [drs_pkg::TIME_W-1:0] t_pipe [LAT];
  logic signed [drs_pkg::TIME_W-1:0] std_at;
  logic signed [drs_pkg::TIME_W-1:0] dst_at;
  logic                              accept;
  logic                              dl_next;

  assign accept = start && !busy;

  drs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .std_cfg (std_cfg),
    .dst_cfg (dst_cfg)
  );

  drs_year u_year (
    .clk   (clk),
    .year  (calendar_year),
    .leap  (leap),
    .ydays (ydays)
  );

  drs_rule u_std (
    .clk   (clk),
    .cfg   (std_cfg),
    .year  (calendar_year),
    .leap  (leap),
    .ydays (ydays),
    .chg   (chg_std)
  );

  drs_rule u_dst (
    .clk   (clk),
    .cfg   (dst_cfg),
    .year  (calendar_year),
    .leap  (leap),
    .ydays (ydays),
    .chg   (chg_dst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], accept};
      done <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    t_pipe[0] <= utc_seconds;
    for (int i = 1; i < LAT; i++) begin
      t_pipe[i] <= t_pipe[i-1];
    end
  end

  always_comb begin
    std_at = 64'(chg_std);
    dst_at = 64'(chg_dst);
    if (std_at > dst_at) begin
      dl_next = (t_pipe[LAT-1] < dst_at) || (t_pipe[LAT-1] >= std_at);
    end else begin
      dl_next = (t_pipe[LAT-1] >= std_at) && (t_pipe[LAT-1] < dst_at);
    end
  end

  always_ff @(posedge clk) begin
    is_daylight <= dl_next;
    utc_offset  <= dl_next ? dst_cfg.offset : std_cfg.offset;
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT + 1))
    else $error("Result strobe without a word taken six cycles earlier.");

  a_offset_matches_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (utc_offset == (is_daylight ? dst_cfg.offset : std_cfg.offset)))
    else $error("Offset does not belong to the daylight flag.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("Pipeline not cleared by reset.");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the daylight rule selector. Every accepted word is
// predicted from the programmed standard and daylight rules. The predicted
// flag and offset are queued and compared with each done strobe in order.
// Stimulus is mostly instants close to the yearly rule changes. The rules
// are reprogrammed over the APB port between phases, including extreme and
// out-of-range settings.
// ----------------------------------------------------------------------------
module tb;
  import drs_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 11;
  localparam int WORDS_PHASE  = 160;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [KIND_W-1:0] KIND_MWD_ALIAS = 2'd3;

  typedef struct packed {
    logic                    dl;
    logic signed [OFF_W-1:0] off;
  } verdict_t;

  class daylight_scoreboard;
    verdict_t outstanding_q[$];
    int errors;
    int checked;
    int daylight_seen;

    function void note_word(verdict_t v);
      outstanding_q.push_back(v);
    endfunction

    function void check_result(logic dl, logic signed [OFF_W-1:0] off);
      verdict_t want;
      if (outstanding_q.size() == 0) begin
        $display("%0t: unexpected result, is_daylight=%0b utc_offset=%0d", $time, dl, off);
        errors++;
        return;
      end
      want = outstanding_q.pop_front();
      checked++;
      if (dl === 1'b1) daylight_seen++;
      if (dl !== want.dl) begin
        $display("%0t: is_daylight expected %0b actual %0b", $time, want.dl, dl);
        errors++;
      end
      if (off !== want.off) begin
        $display("%0t: utc_offset expected %0d actual %0d", $time, want.off, off);
        errors++;
      end
    endfunction

    function int outstanding();
      return outstanding_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [TIME_W-1:0]  utc_seconds = '0;
  logic [YEAR_W-1:0]         calendar_year = '0;
  logic                      done;
  logic                      is_daylight;
  logic signed [OFF_W-1:0]   utc_offset;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  daylight_scoreboard sb = new;
  rule_cfg_t std_rule;
  rule_cfg_t dst_rule;
  int words_sent;
  int reg_writes;
  int stall_cycles;

  dst_rule_offset_select uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .utc_seconds(utc_seconds), .calendar_year(calendar_year),
    .done(done), .is_daylight(is_daylight), .utc_offset(utc_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic bit leap(int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int m, bit lp);
    case (m)
      2:             return lp ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // UTC second at which a rule takes effect in the given year.
  function automatic longint rule_instant(rule_cfg_t r, int year);
    longint days;
    int p, dayv, wk, mon, wd, mlen, mm, yy, c, cy, v, dow, d;
    bit lp;
    days = 0;
    lp = leap(year);
    dayv = int'(r.date[8:0]);
    if (year > 1970) begin
      p = year - 1;
      days = longint'(year - 1970) * 365 + (p / 4 - 492) - (p / 100 - 19) + (p / 400 - 4);
    end
    if (r.kind == KIND_JULIAN) begin
      days += dayv - 1;
      if (dayv >= 60 && lp) days += 1;
    end else if (r.kind == KIND_ZERO_DAY) begin
      days += dayv;
    end else begin
      wk = int'(r.date[11:9]);
      mon = int'(r.date[15:12]);
      wd = dayv;
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      if (wd > 6) wd = 6;
      for (int i = 1; i < mon; i++) days += month_days(i, lp);
      mlen = month_days(mon, lp);
      mm = (mon < 3) ? mon + 12 : mon;
      yy = ((mon < 3) ? year - 1 : year) + 400;
      c = yy / 100;
      cy = yy % 100;
      v = 13 * (mm + 1) / 5 + cy + cy / 4 + c / 4 - 2 * c;
      dow = ((v % 7) + 7) % 7;
      d = (wd < dow) ? wd + 7 - dow : wd - dow;
      for (int i = 1; i < wk; i++) begin
        if (d + 7 >= mlen) break;
        d += 7;
      end
      days += d;
    end
    return days * 86400 - longint'(r.offset) + longint'(r.rtime);
  endfunction

  function automatic verdict_t predict_daylight(longint t, int year);
    verdict_t v;
    longint chs, chd;
    chs = rule_instant(std_rule, year);
    chd = rule_instant(dst_rule, year);
    if (chs > chd) v.dl = (t < chd) || (t >= chs);
    else           v.dl = (t >= chs) && (t < chd);
    v.off = v.dl ? dst_rule.offset : std_rule.offset;
    return v;
  endfunction

  function automatic logic signed [OFF_W-1:0] random_secs();
    if ($urandom_range(0, 4) == 0) return OFF_W'($urandom());
    return OFF_W'(int'($urandom_range(0, 179998)) - 89999);
  endfunction

  function automatic rule_cfg_t random_rule();
    rule_cfg_t r;
    r.kind = KIND_W'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0)
      r.date = DATE_W'($urandom());
    else if (r.kind >= KIND_MWD)
      r.date = {4'($urandom_range(1, 12)), 3'($urandom_range(1, 5)), 9'($urandom_range(0, 6))};
    else
      r.date = {7'd0, 9'($urandom_range(0, 365))};
    r.rtime = random_secs();
    r.offset = random_secs();
    return r;
  endfunction

  task automatic send_word(longint t, int year);
    start <= 1'b1;
    utc_seconds <= t;
    calendar_year <= YEAR_W'(year);
    do @(posedge clk); while (busy);
    sb.note_word(predict_daylight(t, year));
    words_sent++;
  endtask

  task automatic send_boundaries(int year);
    longint a, b;
    a = rule_instant(std_rule, year);
    b = rule_instant(dst_rule, year);
    send_word(a - 1, year);
    send_word(a, year);
    send_word(b - 1, year);
    send_word(b, year);
  endtask

  task automatic send_random_word();
    int year, sel;
    longint anchor, t;
    sel = $urandom_range(0, 99);
    if (sel < 50)      year = $urandom_range(1970, 2100);
    else if (sel < 90) year = $urandom_range(1970, 9999);
    else               year = $urandom_range(0, (1 << YEAR_W) - 1);
    anchor = $urandom_range(0, 1) ? rule_instant(std_rule, year) : rule_instant(dst_rule, year);
    sel = $urandom_range(0, 99);
    if (sel < 45)      t = anchor + longint'($urandom_range(0, 8)) - 4;
    else if (sel < 70) t = anchor + longint'($urandom_range(0, 172800)) - 86400;
    else if (sel < 90) t = anchor + longint'($urandom_range(0, 40000000)) - 20000000;
    else               t = {$urandom(), $urandom()};
    send_word(t, year);
  endtask

  task automatic send_batch(int n);
    int left, blen, gap;
    left = n;
    while (left > 0) begin
      blen = $urandom_range(1, 24);
      if (blen > left) blen = left;
      repeat (blen) send_random_word();
      left -= blen;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v, int w);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() << w) : 32'd0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (v & ((32'd1 << w) - 1)) | junk;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_writes++;
  endtask

  task automatic program_rules(rule_cfg_t s, rule_cfg_t d);
    write_reg(REG_STD_KIND, 32'(s.kind), KIND_W);
    write_reg(REG_STD_DATE, 32'(s.date), DATE_W);
    write_reg(REG_STD_TIME, 32'(s.rtime), OFF_W);
    write_reg(REG_STD_OFF, 32'(s.offset), OFF_W);
    write_reg(REG_DST_KIND, 32'(d.kind), KIND_W);
    write_reg(REG_DST_DATE, 32'(d.date), DATE_W);
    write_reg(REG_DST_TIME, 32'(d.rtime), OFF_W);
    write_reg(REG_DST_OFF, 32'(d.offset), OFF_W);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    std_rule = s;
    dst_rule = d;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) sb.check_result(is_daylight, utc_offset);
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding.", $time, sb.outstanding());
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    std_rule = STD_CFG_RESET;
    dst_rule = DST_CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(64'sh8000_0000_0000_0000, 1970);
    send_word(64'sh7FFF_FFFF_FFFF_FFFF, 9999);
    send_word(0, 0);
    send_word(-1, (1 << YEAR_W) - 1);
    send_word(0, 1969);
    send_boundaries(2024);
    send_boundaries(2100);
    send_boundaries(2000);
    send_batch(WORDS_PHASE);

    for (int ph = 1; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: program_rules('{KIND_ZERO_DAY, 16'd0, -18'sd89999, -18'sd89999},
                         '{KIND_JULIAN, 16'd365, 18'sd89999, 18'sd89999});
        2: program_rules('{KIND_MWD_ALIAS, 16'hFFFF, 18'sh1FFFF, 18'sh20000},
                         '{KIND_JULIAN, 16'd0, -18'sd89999, 18'sd89999});
        3: program_rules('{KIND_MWD, {4'd10, 3'd5, 9'd0}, 18'sd3600, 18'sd0},
                         '{KIND_MWD, {4'd3, 3'd5, 9'd0}, 18'sd3600, 18'sd3600});
        4: program_rules('{KIND_JULIAN, 16'd60, 18'sd7200, 18'sd36000},
                         '{KIND_ZERO_DAY, 16'd511, 18'sd0, 18'sd39600});
        5: program_rules('{KIND_MWD, {4'd0, 3'd0, 9'd7}, 18'sh20000, -18'sd18000},
                         '{KIND_MWD, {4'd15, 3'd7, 9'd511}, 18'sh1FFFF, -18'sd14400});
        default: program_rules(random_rule(), random_rule());
      endcase
      send_boundaries(2024);
      send_boundaries($urandom_range(1970, 9999));
      send_batch(WORDS_PHASE);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words under %0d rule settings with %0d register writes.",
             words_sent, PHASES, reg_writes);
    $display("Checked %0d results, %0d of them in daylight time.", sb.checked, sb.daylight_seen);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/drs_pkg.sv
hw/rtl/drs_regs.sv
hw/rtl/drs_year.sv
hw/rtl/drs_rule.sv
hw/rtl/dst_rule_offset_select.sv
tb/tb.sv
